[sv/tdpt_pkg.sv]
// ---------------------------------------------------------------------------
// tdpt_pkg
// Shared constants and types for the trial division prime test core.
// ---------------------------------------------------------------------------
package tdpt_pkg;

   // Default width of the candidate value
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Width of the first-divisor register and its reset value
   localparam int          CFG_WIDTH           = 8;
   localparam logic [7:0]  FIRST_DIVISOR_RESET = 8'd2;

   // Smallest meaningful trial divisor
   localparam logic [7:0]  MIN_DIVISOR         = 8'd2;

   // Status of the bit-serial divider, seen by the sequencer
   typedef struct packed {
      logic busy;       // division in progress
      logic done;       // quotient and remainder valid this cycle
      logic rem_zero;   // remainder of the finished division is zero
   } div_status_type;

endpackage

[sv/tdpt_div.sv]
// ---------------------------------------------------------------------------
// tdpt_div
// Bit-serial restoring divider. Produces one quotient bit per cycle while
// busy; done is high for a single cycle once the last bit is in. The
// divisor must stay stable while busy.
// ---------------------------------------------------------------------------
module tdpt_div #(
   parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEFAULT,
   parameter int DIV_WIDTH   = (VALUE_WIDTH + 1) / 2 + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [VALUE_WIDTH-1:0]      dividend,
   input  logic [DIV_WIDTH-1:0]        divisor,
   output logic [VALUE_WIDTH-1:0]      quotient,
   output tdpt_pkg::div_status_type    status
);

   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   logic                   busy_ff,  busy_in;
   logic                   done_ff,  done_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [VALUE_WIDTH-1:0] quo_ff,   quo_in;
   logic [DIV_WIDTH-1:0]   rem_ff,   rem_in;

   logic [DIV_WIDTH:0]     shifted;
   logic [DIV_WIDTH:0]     divisor_ext;
   logic                   fits;

   // One restoring step: bring in the next dividend bit, subtract if it fits
   assign shifted     = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign divisor_ext = {1'b0, divisor};
   assign fits        = (shifted >= divisor_ext);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (start && !busy_ff) begin
         busy_in  = 1'b1;
         count_in = CNT_WIDTH'(VALUE_WIDTH);
         quo_in   = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[VALUE_WIDTH-2:0], fits};
         if (fits) begin
            rem_in = DIV_WIDTH'(shifted - divisor_ext);
         end else begin
            rem_in = shifted[DIV_WIDTH-1:0];
         end
         count_in = count_ff - CNT_WIDTH'(1);
         if (count_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control state under reset; datapath needs none
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient        = quo_ff;
   assign status.busy     = busy_ff;
   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

[sv/trial_division_prime_test_core.sv]
// ---------------------------------------------------------------------------
// trial_division_prime_test_core
// Answers whether an unsigned candidate is prime by trial division. A
// request is taken only while no test is running and no finished answer is
// waiting to enter the output register. One response bit follows each
// request. A finished response may wait in the output register while the
// next request is already being tested. Trial divisors run upward from 2
// through a bit-serial divider, which yields both remainder and quotient.
// The search ends at the first divisor leaving remainder zero, or once the
// quotient drops below the divisor. The number of divisors tried is s - 1
// for a candidate whose smallest factor is s, and floor(sqrt(candidate))
// for a prime, about 2^(VALUE_WIDTH/2) at worst. Candidates 0 and 1 skip
// the divider and go straight to the output state. A stall on the output
// register delays the response. A factor counts only when the largest
// proper divisor is at least the configured first divisor (values below 2
// act as 2).
// ---------------------------------------------------------------------------
module trial_division_prime_test_core #(
   parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [VALUE_WIDTH-1:0]           req_candidate,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_is_prime,
   // configuration
   input  logic                             csr_write_en,
   input  logic [tdpt_pkg::CFG_WIDTH-1:0]   csr_first_divisor
);

   localparam int DIV_WIDTH = (VALUE_WIDTH + 1) / 2 + 1;

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   logic [1:0]                       state_ff,     state_in;
   logic [tdpt_pkg::CFG_WIDTH-1:0]   first_div_ff;
   logic [VALUE_WIDTH-1:0]           cand_ff,      cand_in;
   logic [DIV_WIDTH-1:0]             trial_ff,     trial_in;
   logic                             prime_ff,     prime_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_prime_ff, rsp_prime_in;

   logic                             req_accept;
   logic                             div_start;
   logic [VALUE_WIDTH-1:0]           div_quotient;
   tdpt_pkg::div_status_type         div_status;
   logic [tdpt_pkg::CFG_WIDTH-1:0]   first_div_eff;
   logic                             quo_below_trial;
   logic                             quo_reaches_first;
   logic                             out_free;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         first_div_ff <= tdpt_pkg::FIRST_DIVISOR_RESET;
      end else if (csr_write_en) begin
         first_div_ff <= csr_first_divisor;
      end
   end

   // Divisors below two act as two
   assign first_div_eff = (first_div_ff < tdpt_pkg::MIN_DIVISOR) ?
                          tdpt_pkg::MIN_DIVISOR : first_div_ff;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Compare the finished quotient against the trial divisor and first divisor
   assign quo_below_trial   = (div_quotient < VALUE_WIDTH'(trial_ff));
   assign quo_reaches_first = (div_quotient >= VALUE_WIDTH'(first_div_eff));

   // Load the divider with the candidate that the sequencer is about to hold
   tdpt_div #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIV_WIDTH   (DIV_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cand_in),
      .divisor  (trial_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // Sequencer: walk trial divisors, then hand the answer to the output
   always_comb begin
      state_in     = state_ff;
      cand_in      = cand_ff;
      trial_in     = trial_ff;
      prime_in     = prime_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cand_in  = req_candidate;
               trial_in = DIV_WIDTH'(tdpt_pkg::MIN_DIVISOR);
               if (req_candidate[VALUE_WIDTH-1:1] == '0) begin
                  prime_in = 1'b0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               if (quo_below_trial) begin
                  prime_in = 1'b1;
                  state_in = S_OUT;
               end else if (div_status.rem_zero) begin
                  prime_in = !quo_reaches_first;
                  state_in = S_OUT;
               end else begin
                  trial_in = trial_ff + DIV_WIDTH'(1);
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = prime_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // kick the divider on entry to a new trial
      if ((state_ff == S_IDLE && state_in == S_DIV) ||
          (state_ff == S_DIV && div_status.done && state_in == S_DIV)) begin
         div_start = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff      <= cand_in;
      trial_ff     <= trial_in;
      prime_ff     <= prime_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_prime_ff;

   // A new division never starts while one is running
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   // After a start, the sequencer waits in the divide state with the divider busy
   assert property (@(posedge clock) disable iff (reset)
      div_start |=> state_ff == S_DIV && div_status.busy)
      else $error("divider not running after start");

   // Trial divisor stays in [2, 2^(DIV_WIDTH-1)]
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> trial_ff >= DIV_WIDTH'(2) &&
      (!trial_ff[DIV_WIDTH-1] || trial_ff[DIV_WIDTH-2:0] == '0))
      else $error("trial divisor out of range");

   // A response appears only from the output state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_OUT)
      else $error("response raised outside output state");

endmodule
